// File: sv/bresenham_line_rasterizer_defines.svh
// assertion macros used by the rasterizer checker
`ifndef BRESENHAM_LINE_RASTERIZER_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define BRL_ASSERT_HOLDS(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brl check failed");

// next-cycle implication, clocked on clk, off while rst_n is low
`define BRL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brl check failed");

`endif

// File: sv/brl_pkg.sv
// shared constants and types of the line rasterizer
package brl_pkg;

    localparam int BRL_COORD_BITS  = 12;
    localparam int BRL_CFG_BITS    = 12;
    localparam int BRL_INDEX_BITS  = 22;
    localparam int BRL_COLOR_BITS  = 8;
    localparam int BRL_QUEUE_DEPTH = 2;

    localparam logic [BRL_CFG_BITS-1:0] BRL_WIDTH_RESET  = 12'd1024;
    localparam logic [BRL_CFG_BITS-1:0] BRL_HEIGHT_RESET = 12'd1024;

    // command codes
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } brl_kind_t;

    // configuration register indexes
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } brl_reg_t;

    // image geometry handed to the pixel engine
    typedef struct packed {
        logic [BRL_CFG_BITS-1:0] width;
        logic [BRL_CFG_BITS-1:0] height;
    } brl_geom_t;

endpackage

// File: sv/brl_if.sv
// handshake channels of the line rasterizer: commands, pixels, configuration

interface brl_cmd_if import brl_pkg::*; #(parameter int COORD_BITS = BRL_COORD_BITS);
    logic                             valid;
    logic                             ready;
    logic                             command;
    logic signed [COORD_BITS-1:0]     x_start;
    logic signed [COORD_BITS-1:0]     y_start;
    logic signed [COORD_BITS-1:0]     x_end;
    logic signed [COORD_BITS-1:0]     y_end;
    logic        [BRL_COLOR_BITS-1:0] red;
    logic        [BRL_COLOR_BITS-1:0] green;
    logic        [BRL_COLOR_BITS-1:0] blue;
    logic        [BRL_COLOR_BITS-1:0] alpha;

    modport source (
        output valid, command, x_start, y_start, x_end, y_end, red, green, blue, alpha,
        input  ready
    );
    modport sink (
        input  valid, command, x_start, y_start, x_end, y_end, red, green, blue, alpha,
        output ready
    );
endinterface

interface brl_pix_if import brl_pkg::*; #(parameter int COORD_BITS = BRL_COORD_BITS);
    logic                             valid;
    logic                             ready;
    logic signed [COORD_BITS-1:0]     pixel_x;
    logic signed [COORD_BITS-1:0]     pixel_y;
    logic        [BRL_INDEX_BITS-1:0] pixel_index;
    logic                             write_enable;
    logic        [BRL_COLOR_BITS-1:0] out_red;
    logic        [BRL_COLOR_BITS-1:0] out_green;
    logic        [BRL_COLOR_BITS-1:0] out_blue;
    logic        [BRL_COLOR_BITS-1:0] out_alpha;
    logic                             last;

    modport source (
        output valid, pixel_x, pixel_y, pixel_index, write_enable,
               out_red, out_green, out_blue, out_alpha, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_index, write_enable,
               out_red, out_green, out_blue, out_alpha, last,
        output ready
    );
endinterface

interface brl_cfg_if import brl_pkg::*;;
    logic                    valid;
    logic                    ready;
    brl_reg_t                reg_index;
    logic [BRL_CFG_BITS-1:0] data;

    modport source (output valid, reg_index, data, input ready);
    modport sink (input valid, reg_index, data, output ready);
endinterface

// File: sv/brl_queue.sv
// two-entry queue between the command front end and the pixel engine
module brl_queue import brl_pkg::*; #(
    parameter int WIDTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_BITS = (BRL_QUEUE_DEPTH > 1) ? $clog2(BRL_QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(BRL_QUEUE_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(BRL_QUEUE_DEPTH);
    localparam logic [PTR_BITS-1:0] LAST_PTR   = PTR_BITS'(BRL_QUEUE_DEPTH - 1);

    logic [WIDTH-1:0]    slot_reg [BRL_QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                push, pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/brl_front.sv
// command front end: classifies commands and works out the line setup terms
module brl_front import brl_pkg::*; #(
    parameter int COORD_BITS = BRL_COORD_BITS,
    parameter int ENTRY_BITS = 7 * COORD_BITS + 38
) (
    brl_cmd_if.sink               cmd,
    output logic                  push_valid,
    input  logic                  push_ready,
    output logic [ENTRY_BITS-1:0] push_data
);

    localparam int ERR_BITS = COORD_BITS + 2;

    typedef struct packed {
        brl_kind_t                        kind;
        logic signed [COORD_BITS-1:0]     x0;
        logic signed [COORD_BITS-1:0]     y0;
        logic signed [COORD_BITS-1:0]     x1;
        logic signed [COORD_BITS-1:0]     y1;
        logic        [COORD_BITS-1:0]     dx;
        logic signed [COORD_BITS:0]       ndy;
        logic                             sx_neg;
        logic                             sy_neg;
        logic signed [ERR_BITS-1:0]       err;
        logic        [BRL_COLOR_BITS-1:0] alpha;
        logic        [BRL_COLOR_BITS-1:0] blue;
        logic        [BRL_COLOR_BITS-1:0] green;
        logic        [BRL_COLOR_BITS-1:0] red;
    } entry_t;

    entry_t                     entry;
    logic signed [COORD_BITS:0] diff_x, diff_y, abs_x, neg_abs_y;
    logic                       x_up, y_up;

    always_comb
    begin
        diff_x    = {cmd.x_end[COORD_BITS-1], cmd.x_end}
                  - {cmd.x_start[COORD_BITS-1], cmd.x_start};
        diff_y    = {cmd.y_end[COORD_BITS-1], cmd.y_end}
                  - {cmd.y_start[COORD_BITS-1], cmd.y_start};
        x_up      = (cmd.x_end > cmd.x_start);
        y_up      = (cmd.y_end > cmd.y_start);
        abs_x     = x_up ? diff_x : -diff_x;
        neg_abs_y = y_up ? -diff_y : diff_y;

        entry.kind   = brl_kind_t'(cmd.command);
        entry.x0     = cmd.x_start;
        entry.y0     = cmd.y_start;
        entry.x1     = cmd.x_end;
        entry.y1     = cmd.y_end;
        entry.dx     = abs_x[COORD_BITS-1:0];
        entry.ndy    = neg_abs_y;
        entry.sx_neg = !x_up;
        entry.sy_neg = !y_up;
        entry.err    = $signed({2'b00, abs_x[COORD_BITS-1:0]})
                     + $signed({neg_abs_y[COORD_BITS], neg_abs_y});
        entry.red    = cmd.red;
        entry.green  = cmd.green;
        entry.blue   = cmd.blue;
        entry.alpha  = cmd.alpha;
    end

    assign push_valid = cmd.valid;
    assign cmd.ready  = push_ready;
    assign push_data  = entry;

endmodule

// File: sv/brl_back.sv
// pixel engine: bresenham stepping, clipping, index and the pixel output register
module brl_back import brl_pkg::*; #(
    parameter int COORD_BITS = BRL_COORD_BITS,
    parameter int ENTRY_BITS = 7 * COORD_BITS + 38
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  brl_geom_t             geom,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  logic [ENTRY_BITS-1:0] pop_data,
    brl_pix_if.source             pix
);

    localparam int ERR_BITS  = COORD_BITS + 2;
    localparam int CMP_BITS  = (COORD_BITS > BRL_CFG_BITS) ? COORD_BITS : BRL_CFG_BITS;
    localparam int PROD_BITS = COORD_BITS + BRL_CFG_BITS + 1;

    typedef struct packed {
        brl_kind_t                        kind;
        logic signed [COORD_BITS-1:0]     x0;
        logic signed [COORD_BITS-1:0]     y0;
        logic signed [COORD_BITS-1:0]     x1;
        logic signed [COORD_BITS-1:0]     y1;
        logic        [COORD_BITS-1:0]     dx;
        logic signed [COORD_BITS:0]       ndy;
        logic                             sx_neg;
        logic                             sy_neg;
        logic signed [ERR_BITS-1:0]       err;
        logic        [BRL_COLOR_BITS-1:0] alpha;
        logic        [BRL_COLOR_BITS-1:0] blue;
        logic        [BRL_COLOR_BITS-1:0] green;
        logic        [BRL_COLOR_BITS-1:0] red;
    } entry_t;

    entry_t head;

    // line state
    logic                             active_reg, active_next;
    logic signed [COORD_BITS-1:0]     cur_x_reg, cur_y_reg;
    logic signed [COORD_BITS-1:0]     tgt_x_reg, tgt_y_reg;
    logic        [COORD_BITS-1:0]     dx_reg;
    logic signed [COORD_BITS:0]       ndy_reg;
    logic                             sx_neg_reg, sy_neg_reg;
    logic signed [ERR_BITS-1:0]       err_reg;
    logic        [BRL_COLOR_BITS-1:0] red_reg, green_reg, blue_reg, alpha_reg;

    // pixel output register
    logic                             out_valid_reg, out_valid_next;
    logic signed [COORD_BITS-1:0]     out_x_reg, out_y_reg;
    logic        [BRL_INDEX_BITS-1:0] out_index_reg;
    logic                             out_we_reg, out_last_reg;
    logic        [BRL_COLOR_BITS-1:0] out_red_reg, out_green_reg, out_blue_reg, out_alpha_reg;

    logic                             out_free, take_load, take_step;
    logic signed [ERR_BITS:0]         e2, ndy_ext, dx_ext, err_sum;
    logic                             go_x, go_y, at_end, in_image;
    logic        [CMP_BITS-1:0]       x_u, y_u;
    logic        [PROD_BITS-1:0]      lin_index;
    logic signed [COORD_BITS-1:0]     next_x, next_y;
    logic        [BRL_INDEX_BITS-1:0] index_next;

    assign head      = pop_data;
    assign out_free  = !out_valid_reg || pix.ready;
    // loads and idle steps never wait on the output side
    assign pop_ready = (head.kind == CMD_LOAD) || !active_reg || out_free;
    assign take_load = pop_valid && (head.kind == CMD_LOAD);
    assign take_step = pop_valid && (head.kind == CMD_STEP) && active_reg && out_free;

    always_comb
    begin
        e2      = {err_reg, 1'b0};
        ndy_ext = {{2{ndy_reg[COORD_BITS]}}, ndy_reg};
        dx_ext  = {3'b000, dx_reg};
        go_x    = (e2 >= ndy_ext);
        go_y    = (e2 <= dx_ext);
        err_sum = {err_reg[ERR_BITS-1], err_reg}
                + (go_x ? ndy_ext : '0)
                + (go_y ? dx_ext : '0);
        next_x  = go_x ? (sx_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1) : cur_x_reg;
        next_y  = go_y ? (sy_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1) : cur_y_reg;
        at_end  = (cur_x_reg == tgt_x_reg) && (cur_y_reg == tgt_y_reg);

        x_u        = CMP_BITS'($unsigned(cur_x_reg));
        y_u        = CMP_BITS'($unsigned(cur_y_reg));
        in_image   = !cur_x_reg[COORD_BITS-1] && !cur_y_reg[COORD_BITS-1]
                  && (x_u < CMP_BITS'(geom.width)) && (y_u < CMP_BITS'(geom.height));
        lin_index  = PROD_BITS'(y_u) * PROD_BITS'(geom.width) + PROD_BITS'(x_u);
        index_next = in_image ? BRL_INDEX_BITS'(lin_index) : '0;

        active_next = active_reg;
        if (take_load)
        begin
            active_next = 1'b1;
        end
        else if (take_step && at_end)
        begin
            active_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (take_step)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_load)
        begin
            cur_x_reg  <= head.x0;
            cur_y_reg  <= head.y0;
            tgt_x_reg  <= head.x1;
            tgt_y_reg  <= head.y1;
            dx_reg     <= head.dx;
            ndy_reg    <= head.ndy;
            sx_neg_reg <= head.sx_neg;
            sy_neg_reg <= head.sy_neg;
            err_reg    <= head.err;
            red_reg    <= head.red;
            green_reg  <= head.green;
            blue_reg   <= head.blue;
            alpha_reg  <= head.alpha;
        end
        else if (take_step && !at_end)
        begin
            cur_x_reg <= next_x;
            cur_y_reg <= next_y;
            err_reg   <= err_sum[ERR_BITS-1:0];
        end

        if (take_step)
        begin
            out_x_reg     <= cur_x_reg;
            out_y_reg     <= cur_y_reg;
            out_index_reg <= index_next;
            out_we_reg    <= in_image;
            out_last_reg  <= at_end;
            out_red_reg   <= red_reg;
            out_green_reg <= green_reg;
            out_blue_reg  <= blue_reg;
            out_alpha_reg <= alpha_reg;
        end
    end

    assign pix.valid        = out_valid_reg;
    assign pix.pixel_x      = out_x_reg;
    assign pix.pixel_y      = out_y_reg;
    assign pix.pixel_index  = out_index_reg;
    assign pix.write_enable = out_we_reg;
    assign pix.out_red      = out_red_reg;
    assign pix.out_green    = out_green_reg;
    assign pix.out_blue     = out_blue_reg;
    assign pix.out_alpha    = out_alpha_reg;
    assign pix.last         = out_last_reg;

endmodule

// File: sv/bresenham_line_rasterizer.sv
// top level of the bresenham line rasterizer
//
//  port  | direction | transaction
//  ------+-----------+---------------------------------------------------------
//  cmd   | in        | load a line (endpoints, rgba) or step out the next pixel
//  pix   | out       | one pixel: x, y, linear index, write enable, rgba, last
//  cfg   | in        | write image_width or image_height
//
//  one command per cycle sustained while pix.ready holds; a step leaves as a pixel
//  after acceptance via the front setup into the queue, then the stepping engine register
//  the step loop in the engine is one compare-and-add per cycle, so one pixel a cycle
//  a stalled pixel output stops the engine, the two-entry queue then fills and
//  cmd.ready drops; loads and steps while idle drain from the queue regardless
//  reset: queue empty, no line active, width and height back to 1024
//  cfg.ready is always high; a register write takes effect for steps taken after it
module bresenham_line_rasterizer import brl_pkg::*; #(
    parameter int COORD_BITS = BRL_COORD_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    brl_cmd_if.sink   cmd,
    brl_pix_if.source pix,
    brl_cfg_if.sink   cfg
);

    // kind, four endpoints, dx, -dy, two step signs, error term, rgba
    localparam int ENTRY_BITS = 7 * COORD_BITS + 38;

    logic                  push_valid, push_ready;
    logic [ENTRY_BITS-1:0] push_data;
    logic                  pop_valid, pop_ready;
    logic [ENTRY_BITS-1:0] pop_data;
    brl_geom_t             geom_reg, geom_next;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_comb
    begin
        geom_next = geom_reg;
        if (cfg.valid)
        begin
            case (cfg.reg_index)
                REG_IMAGE_WIDTH:  geom_next.width  = cfg.data;
                REG_IMAGE_HEIGHT: geom_next.height = cfg.data;
                default:          geom_next        = geom_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.width  <= BRL_WIDTH_RESET;
            geom_reg.height <= BRL_HEIGHT_RESET;
        end
        else
        begin
            geom_reg <= geom_next;
        end
    end

    // front end: decode and line setup
    brl_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_front (
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decoupling queue
    brl_queue #(
        .WIDTH (ENTRY_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back end: stepping, clipping and pixel output
    brl_back #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .pix       (pix)
    );

endmodule

// File: sv/brl_checker.sv
// port-level checks on the rasterizer pixel output, bound to the top level
`include "bresenham_line_rasterizer_defines.svh"

module brl_checker import brl_pkg::*; #(
    parameter int COORD_BITS = BRL_COORD_BITS
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      pix_valid,
    input logic                      pix_ready,
    input logic [COORD_BITS-1:0]     pix_x,
    input logic [COORD_BITS-1:0]     pix_y,
    input logic [BRL_INDEX_BITS-1:0] pix_index,
    input logic                      pix_we,
    input logic                      pix_last
);

    // a stalled pixel keeps its place and coordinates
    `BRL_ASSERT_NEXT(a_pix_hold, pix_valid && !pix_ready, pix_valid && $stable(pix_x) && $stable(pix_y) && $stable(pix_last))

    // clipped pixels carry a zero index
    `BRL_ASSERT_HOLDS(a_clip_index, pix_valid && !pix_we, pix_index == '0)

    // a written pixel never has a negative coordinate
    `BRL_ASSERT_HOLDS(a_we_nonneg, pix_valid && pix_we, !pix_x[COORD_BITS-1] && !pix_y[COORD_BITS-1])

endmodule

bind bresenham_line_rasterizer brl_checker #(
    .COORD_BITS (COORD_BITS)
) u_brl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix.valid),
    .pix_ready (pix.ready),
    .pix_x     (pix.pixel_x),
    .pix_y     (pix.pixel_y),
    .pix_index (pix.pixel_index),
    .pix_we    (pix.write_enable),
    .pix_last  (pix.last)
);

// File: sim/bresenham_line_rasterizer_tb.sv
// self-checking testbench of the bresenham line rasterizer: directed table, then random lines
module bresenham_line_rasterizer_tb import brl_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_MIN   = -(1 << (BRL_COORD_BITS - 1));
    localparam int COORD_MAX   = (1 << (BRL_COORD_BITS - 1)) - 1;
    localparam int IDLE_HEAVY  = 47;
    localparam int IDLE_LIGHT  = 17;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 244;
    localparam int SETTLE      = 8;

    // one command transaction as the sender sees it
    typedef struct {
        brl_kind_t                   kind;
        logic signed [BRL_COORD_BITS-1:0] x0, y0, x1, y1;
        logic [BRL_COLOR_BITS-1:0]   red, green, blue, alpha;
    } line_cmd_t;

    // one pixel transaction as the frame buffer sees it
    typedef struct {
        logic signed [BRL_COORD_BITS-1:0] x, y;
        logic [BRL_INDEX_BITS-1:0]   index;
        logic                        we;
        logic [BRL_COLOR_BITS-1:0]   red, green, blue, alpha;
        logic                        last;
    } pixel_t;

    // directed row; on a pinned step row x0/y0 and the color slots hold the
    // pixel the step must produce, index/we/last hold the rest of it
    typedef struct {
        brl_kind_t                   kind;
        logic signed [BRL_COORD_BITS-1:0] x0, y0, x1, y1;
        logic [BRL_COLOR_BITS-1:0]   red, green, blue, alpha;
        bit                          pinned;
        logic [BRL_INDEX_BITS-1:0]   index;
        bit                          we;
        bit                          last;
    } stim_row_t;

    logic clk;
    logic rst_n;

    brl_cmd_if cmd_ch ();
    brl_pix_if pix_ch ();
    brl_cfg_if cfg_ch ();

    bresenham_line_rasterizer DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .pix   (pix_ch),
        .cfg   (cfg_ch)
    );

    // typed-in expectation travelling alongside the command payload
    bit     pin_valid;
    pixel_t pin_pixel;

    // idle knobs per phase, in percent of cycles
    int send_idle_pct;
    int stall_pct;

    // pixels still owed by the block, oldest first
    pixel_t owed_pixels[$];

    int mismatches;
    int pixels_checked;
    int loads_taken;
    int steps_taken;

    // line state mirrored from the rasterizer
    bit                               line_busy   = 1'b0;
    logic signed [BRL_COORD_BITS-1:0] pos_x       = '0;
    logic signed [BRL_COORD_BITS-1:0] pos_y       = '0;
    logic signed [BRL_COORD_BITS-1:0] goal_x      = '0;
    logic signed [BRL_COORD_BITS-1:0] goal_y      = '0;
    logic [BRL_COORD_BITS-1:0]        span_x      = '0;
    logic signed [BRL_COORD_BITS:0]   span_y_neg  = '0;
    bit                               walk_x_down = 1'b0;
    bit                               walk_y_down = 1'b0;
    logic signed [BRL_COORD_BITS+1:0] err_acc     = '0;
    logic [31:0]                      ink         = '0;
    logic [BRL_CFG_BITS-1:0]          pitch       = BRL_WIDTH_RESET;
    logic [BRL_CFG_BITS-1:0]          rows        = BRL_HEIGHT_RESET;

    // directed part, walked top to bottom under the reset geometry (1024 x 1024)
    stim_row_t directed_rows[$] = '{
        // step straight out of reset: no line, nothing comes out
        '{CMD_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0},
        // single-pixel line at the origin, then a step once idle again
        '{CMD_LOAD, 0, 0, 0, 0, 8'h01, 8'h02, 8'h03, 8'h04, 0, 0, 0, 0},
        '{CMD_STEP, 0, 0, 0, 0, 8'h01, 8'h02, 8'h03, 8'h04, 1, 0, 1, 1},
        '{CMD_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0},
        // most negative corner, clipped
        '{CMD_LOAD, -2048, -2048, -2048, -2048, 8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0},
        '{CMD_STEP, -2048, -2048, 0, 0, 8'hff, 8'hff, 8'hff, 8'hff, 1, 0, 0, 1},
        // most positive corner, clipped
        '{CMD_LOAD, 2047, 2047, 2047, 2047, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0},
        '{CMD_STEP, 2047, 2047, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1, 0, 0, 1},
        // last pixel inside the image
        '{CMD_LOAD, 1023, 1023, 1023, 1023, 8'ha5, 8'h5a, 8'hc3, 8'h3c, 0, 0, 0, 0},
        '{CMD_STEP, 1023, 1023, 0, 0, 8'ha5, 8'h5a, 8'hc3, 8'h3c, 1, 22'd1048575, 1, 1},
        // x equal to the width is already outside
        '{CMD_LOAD, 1024, 7, 1024, 7, 8'h11, 8'h22, 8'h33, 8'h44, 0, 0, 0, 0},
        '{CMD_STEP, 1024, 7, 0, 0, 8'h11, 8'h22, 8'h33, 8'h44, 1, 0, 0, 1},
        // row pitch in the index: 3 * 1024 + 5
        '{CMD_LOAD, 5, 3, 5, 3, 8'h80, 8'h40, 8'h20, 8'h10, 0, 0, 0, 0},
        '{CMD_STEP, 5, 3, 0, 0, 8'h80, 8'h40, 8'h20, 8'h10, 1, 22'd3077, 1, 1},
        // shallow line, cut short by a load while still active
        '{CMD_LOAD, 0, 0, 3, 1, 8'h12, 8'h34, 8'h56, 8'h78, 0, 0, 0, 0},
        '{CMD_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0},
        '{CMD_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0},
        // leftward and downward, starting just above the image
        '{CMD_LOAD, 10, -1, -2, 5, 8'h9a, 8'hbc, 8'hde, 8'hf0, 0, 0, 0, 0},
        '{CMD_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0},
        '{CMD_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0},
        '{CMD_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0},
        // vertical, walking up
        '{CMD_LOAD, 0, 5, 0, -5, 8'h0f, 8'hf0, 8'h0f, 8'hf0, 0, 0, 0, 0},
        '{CMD_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0},
        // full-range diagonal
        '{CMD_LOAD, -2048, 2047, 2047, -2048, 8'h55, 8'haa, 8'h55, 8'haa, 0, 0, 0, 0},
        '{CMD_STEP, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0}
    };

    // one line per mismatch, and a count
    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("pixel %0d %s got 0x%0h want 0x%0h",
                                    pixels_checked, name, got, want));
    endtask

    // one bresenham command against the mirrored line state; 1 when a pixel is due
    function automatic bit rasterize_next(input line_cmd_t item, output pixel_t px);
        int x0, y0, x1, y1;
        int cx, cy, dx, ndy, acc, twice, w, h;
        int unsigned lin;
        bit in_image;
        px = '{default: 0};
        if (item.kind == CMD_LOAD)
        begin
            x0 = item.x0;
            y0 = item.y0;
            x1 = item.x1;
            y1 = item.y1;
            dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
            ndy = (y1 > y0) ? y0 - y1 : y1 - y0;
            pos_x       = item.x0;
            pos_y       = item.y0;
            goal_x      = item.x1;
            goal_y      = item.y1;
            span_x      = BRL_COORD_BITS'(dx);
            span_y_neg  = (BRL_COORD_BITS+1)'(ndy);
            walk_x_down = !(x0 < x1);
            walk_y_down = !(y0 < y1);
            err_acc     = (BRL_COORD_BITS+2)'(dx + ndy);
            ink         = {item.alpha, item.blue, item.green, item.red};
            line_busy   = 1'b1;
            return 1'b0;
        end
        // step with no line: ignored
        if (!line_busy)
            return 1'b0;
        cx = pos_x;
        cy = pos_y;
        w  = int'(pitch);
        h  = int'(rows);
        in_image = cx >= 0 && cy >= 0 && cx < w && cy < h;
        lin = in_image ? (cy * w + cx) : 0;
        px.x     = pos_x;
        px.y     = pos_y;
        px.index = lin[BRL_INDEX_BITS-1:0];
        px.we    = in_image;
        px.red   = ink[7:0];
        px.green = ink[15:8];
        px.blue  = ink[23:16];
        px.alpha = ink[31:24];
        px.last  = (pos_x == goal_x) && (pos_y == goal_y);
        if (px.last)
        begin
            line_busy = 1'b0;
        end
        else
        begin
            acc   = err_acc;
            twice = 2 * acc;
            dx    = int'(span_x);
            ndy   = int'(span_y_neg);
            if (twice >= ndy)
            begin
                acc += ndy;
                cx  += walk_x_down ? -1 : 1;
            end
            if (twice <= dx)
            begin
                acc += dx;
                cy  += walk_y_down ? -1 : 1;
            end
            pos_x   = BRL_COORD_BITS'(cx);
            pos_y   = BRL_COORD_BITS'(cy);
            err_acc = (BRL_COORD_BITS+2)'(acc);
        end
        return 1'b1;
    endfunction

    function automatic int clamp_coord(input int v);
        return (v < COORD_MIN) ? COORD_MIN : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    function automatic int span_of(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // a coordinate mostly around the image, sometimes anywhere, sometimes at an extreme
    function automatic int pick_axis(input int extent);
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return clamp_coord(int'($urandom_range(extent + 40)) - 20);
        if (r < 80)
            return int'($urandom_range(4095)) + COORD_MIN;
        case ($urandom_range(3))
            0:       return COORD_MIN;
            1:       return -1;
            2:       return 0;
            default: return COORD_MAX;
        endcase
    endfunction

    // step with random payload bits, which the block must not look at
    function automatic line_cmd_t random_step();
        line_cmd_t item;
        item.kind  = CMD_STEP;
        item.x0    = BRL_COORD_BITS'($urandom);
        item.y0    = BRL_COORD_BITS'($urandom);
        item.x1    = BRL_COORD_BITS'($urandom);
        item.y1    = BRL_COORD_BITS'($urandom);
        item.red   = BRL_COLOR_BITS'($urandom);
        item.green = BRL_COLOR_BITS'($urandom);
        item.blue  = BRL_COLOR_BITS'($urandom);
        item.alpha = BRL_COLOR_BITS'($urandom);
        return item;
    endfunction

    // offer one command transaction, with a random gap first; valid stays up after
    task automatic send_command(input line_cmd_t item, input bit pinned, input pixel_t pin);
        if ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= item.kind;
        cmd_ch.x_start <= item.x0;
        cmd_ch.y_start <= item.y0;
        cmd_ch.x_end   <= item.x1;
        cmd_ch.y_end   <= item.y1;
        cmd_ch.red     <= item.red;
        cmd_ch.green   <= item.green;
        cmd_ch.blue    <= item.blue;
        cmd_ch.alpha   <= item.alpha;
        pin_valid      <= pinned;
        pin_pixel      <= pin;
        do @(posedge clk); while (!cmd_ch.ready);
    endtask

    task automatic write_register(input brl_reg_t which, input logic [BRL_CFG_BITS-1:0] value);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= which;
        cfg_ch.data      <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // stop offering, wait for every owed pixel, then let the pipe settle
    task automatic drain_block();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (owed_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // mostly whole lines with random content, plus cut lines, stray steps and wild loads
    task automatic run_random_phase(input int budget);
        int sent, n, extra, r;
        int x0, y0, x1, y1, length;
        line_cmd_t item;
        pixel_t nopin;
        nopin = '{default: 0};
        sent  = 0;
        while (sent < budget)
        begin
            r = $urandom_range(99);
            if (r < 80)
            begin
                item      = random_step();
                item.kind = CMD_LOAD;
                x0 = pick_axis(int'(pitch));
                y0 = pick_axis(int'(rows));
                if ($urandom_range(99) < 5)
                begin
                    // start equals end
                    x1 = x0;
                    y1 = y0;
                end
                else if ($urandom_range(99) < 4)
                begin
                    // rare long line anywhere in the coordinate range
                    x1 = int'($urandom_range(4095)) + COORD_MIN;
                    y1 = int'($urandom_range(4095)) + COORD_MIN;
                end
                else
                begin
                    x1 = clamp_coord(x0 + int'($urandom_range(48)) - 24);
                    y1 = clamp_coord(y0 + int'($urandom_range(48)) - 24);
                end
                item.x0 = BRL_COORD_BITS'(x0);
                item.y0 = BRL_COORD_BITS'(y0);
                item.x1 = BRL_COORD_BITS'(x1);
                item.y1 = BRL_COORD_BITS'(y1);
                length  = ((span_of(x0, x1) > span_of(y0, y1)) ?
                           span_of(x0, x1) : span_of(y0, y1)) + 1;
                if ($urandom_range(99) < 85)
                begin
                    n     = length;
                    extra = $urandom_range(2);
                end
                else
                begin
                    // broken sequence: the next load drops this line
                    n     = $urandom_range(length - 1);
                    extra = 0;
                end
                if (n > budget - sent - 1)
                begin
                    n     = budget - sent - 1;
                    extra = 0;
                end
                send_command(item, 1'b0, nopin);
                repeat (n) send_command(random_step(), 1'b0, nopin);
                // steps past the end point are ignored
                repeat (extra) send_command(random_step(), 1'b0, nopin);
                sent += 1 + n + extra;
            end
            else if (r < 90)
            begin
                send_command(random_step(), 1'b0, nopin);
                sent++;
            end
            else
            begin
                // load with every payload bit random
                item      = random_step();
                item.kind = CMD_LOAD;
                n         = $urandom_range(3);
                send_command(item, 1'b0, nopin);
                repeat (n) send_command(random_step(), 1'b0, nopin);
                sent += 1 + n;
            end
        end
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // pixel sink, stalling at the current rate
    initial
    begin
        pix_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            pix_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watch all three channels: config writes, pixel checks, command prediction
    always @(posedge clk)
    begin
        line_cmd_t seen;
        pixel_t    guess;
        pixel_t    head;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.reg_index == REG_IMAGE_WIDTH)
                    pitch = cfg_ch.data;
                else if (cfg_ch.reg_index == REG_IMAGE_HEIGHT)
                    rows = cfg_ch.data;
            end
            if (pix_ch.valid && pix_ch.ready)
            begin
                if (owed_pixels.size() == 0)
                begin
                    flag_mismatch($sformatf("pixel (%0d,%0d) with nothing owed",
                                            pix_ch.pixel_x, pix_ch.pixel_y));
                end
                else
                begin
                    head = owed_pixels.pop_front();
                    compare_field("pixel_x", pix_ch.pixel_x, head.x);
                    compare_field("pixel_y", pix_ch.pixel_y, head.y);
                    compare_field("pixel_index", pix_ch.pixel_index, head.index);
                    compare_field("write_enable", pix_ch.write_enable, head.we);
                    compare_field("out_red", pix_ch.out_red, head.red);
                    compare_field("out_green", pix_ch.out_green, head.green);
                    compare_field("out_blue", pix_ch.out_blue, head.blue);
                    compare_field("out_alpha", pix_ch.out_alpha, head.alpha);
                    compare_field("last", pix_ch.last, head.last);
                end
                pixels_checked++;
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                seen.kind  = brl_kind_t'(cmd_ch.command);
                seen.x0    = cmd_ch.x_start;
                seen.y0    = cmd_ch.y_start;
                seen.x1    = cmd_ch.x_end;
                seen.y1    = cmd_ch.y_end;
                seen.red   = cmd_ch.red;
                seen.green = cmd_ch.green;
                seen.blue  = cmd_ch.blue;
                seen.alpha = cmd_ch.alpha;
                if (seen.kind == CMD_LOAD)
                    loads_taken++;
                else
                    steps_taken++;
                // a typed-in pixel wins over the computed one
                if (rasterize_next(seen, guess) || pin_valid)
                    owed_pixels.push_back(pin_valid ? pin_pixel : guess);
            end
        end
    end

    // stimulus and the verdict
    initial
    begin
        line_cmd_t item;
        pixel_t    pin;
        int        w, h;
        int        phase_width [PHASE_COUNT] = '{2048, 1, 0, 4095, 640, 7, 0, 3};
        int        phase_height[PHASE_COUNT] = '{2048, 1, 5, 4095, 480, 0, 0, 2048};

        // every input known from time zero
        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = CMD_LOAD;
        cmd_ch.x_start   = '0;
        cmd_ch.y_start   = '0;
        cmd_ch.x_end     = '0;
        cmd_ch.y_end     = '0;
        cmd_ch.red       = '0;
        cmd_ch.green     = '0;
        cmd_ch.blue      = '0;
        cmd_ch.alpha     = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = REG_IMAGE_WIDTH;
        cfg_ch.data      = '0;
        pin_valid        = 1'b0;
        pin_pixel        = '{default: 0};
        send_idle_pct    = 0;
        stall_pct        = 0;
        mismatches       = 0;
        pixels_checked   = 0;
        loads_taken      = 0;
        steps_taken      = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under the reset geometry, no idling
        foreach (directed_rows[i])
        begin
            item.kind  = directed_rows[i].kind;
            item.x0    = directed_rows[i].x0;
            item.y0    = directed_rows[i].y0;
            item.x1    = directed_rows[i].x1;
            item.y1    = directed_rows[i].y1;
            item.red   = directed_rows[i].red;
            item.green = directed_rows[i].green;
            item.blue  = directed_rows[i].blue;
            item.alpha = directed_rows[i].alpha;
            pin = '{x: directed_rows[i].x0, y: directed_rows[i].y0,
                    index: directed_rows[i].index, we: directed_rows[i].we,
                    red: directed_rows[i].red, green: directed_rows[i].green,
                    blue: directed_rows[i].blue, alpha: directed_rows[i].alpha,
                    last: directed_rows[i].last};
            send_command(item, directed_rows[i].pinned, pin);
        end
        drain_block();

        // random phases, each with its own geometry and idle pattern
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            w = phase_width[p];
            h = phase_height[p];
            // one phase picks a random in-range geometry instead
            if (p == PHASE_COUNT - 2)
            begin
                w = $urandom_range(2048, 1);
                h = $urandom_range(2048, 1);
            end
            write_register(REG_IMAGE_WIDTH, BRL_CFG_BITS'(w));
            write_register(REG_IMAGE_HEIGHT, BRL_CFG_BITS'(h));
            cfg_ch.valid <= 1'b0;
            @(posedge clk);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = IDLE_HEAVY;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = IDLE_HEAVY;
                end
                default:
                begin
                    send_idle_pct = IDLE_LIGHT;
                    stall_pct     = IDLE_LIGHT;
                end
            endcase
            run_random_phase(PHASE_ITEMS);
            drain_block();
        end

        $display("covered %0d loads and %0d steps, %0d pixels compared", loads_taken,
                 steps_taken, pixels_checked);
        $display("geometries from 0 to 4095 wide and high, four idle patterns on both sides");
        if (mismatches == 0)
            $display("bresenham_line_rasterizer_tb passed");
        else
            $display("bresenham_line_rasterizer_tb failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("bresenham_line_rasterizer_tb failed");
        $finish;
    end

endmodule
